@@ design/w2p_pkg.sv @@
`timescale 1ns / 1ps
package w2p_pkg;
  localparam int CfgW  = 20;
  // camera-frame coordinate width: rotated (~40 bits) plus translation
  localparam int CamW  = 52;
  // rotation entry after rounding to Q.20
  localparam int RotW  = 27;
  localparam int NumW  = CamW + CfgW + 1;  // f * x product
  // divider: quotient bits per register stage, and the stage count
  localparam int DivStep   = 4;
  localparam int DivStages = (NumW + DivStep - 1) / DivStep;

  localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
  localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] CFG_CENTER_X = 2'd2;
  localparam logic [1:0] CFG_CENTER_Y = 2'd3;

  // quaternion products, one set per item
  typedef struct packed {
    logic signed [33:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  } quat_prod_t;

  typedef struct packed {
    logic              depth_zero;
    logic              saturated;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } pix_t;
endpackage

@@ design/w2p_rotate.sv @@
`timescale 1ns / 1ps
// Quaternion to matrix, matrix times point, plus translation.
// Four register stages; advances when en is high.
module w2p_rotate (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [31:0]        px, py, pz,
  input  logic signed [15:0]        qw, qx, qy, qz,
  input  logic signed [31:0]        tx, ty, tz,
  output logic signed [w2p_pkg::CamW-1:0] cx, cy, cz
);
  localparam int RW = w2p_pkg::RotW;

  // stage 1: quaternion products
  w2p_pkg::quat_prod_t qp;
  logic signed [31:0] p1 [3];
  logic signed [31:0] t1 [3];
  logic signed [31:0] p2 [3];
  logic signed [31:0] t2 [3];
  logic signed [31:0] t3 [3];
  logic signed [RW-1:0] r2 [9];
  logic signed [RW-1:0] r_n [9];
  logic signed [60:0] m3 [9];
  logic signed [w2p_pkg::CamW-1:0] c_n [3];
  logic signed [63:0] acc;
  logic signed [36:0] e [9];
  logic signed [36:0] er [9];

  always_ff @(posedge clk) begin
    if (en) begin
      qp.ww <= 34'(qw * qw); qp.xx <= 34'(qx * qx);
      qp.yy <= 34'(qy * qy); qp.zz <= 34'(qz * qz);
      qp.xy <= 34'(qx * qy); qp.xz <= 34'(qx * qz);
      qp.yz <= 34'(qy * qz); qp.wx <= 34'(qw * qx);
      qp.wy <= 34'(qw * qy); qp.wz <= 34'(qw * qz);
      p1 <= '{px, py, pz};
      t1 <= '{tx, ty, tz};
    end
  end

  // stage 2: matrix entries, rounded from Q.28 to Q.20
  always_comb begin
    e[0] = 37'(qp.ww) + 37'(qp.xx) - 37'(qp.yy) - 37'(qp.zz);
    e[1] = 37'(2) * (37'(qp.xy) - 37'(qp.wz));
    e[2] = 37'(2) * (37'(qp.xz) + 37'(qp.wy));
    e[3] = 37'(2) * (37'(qp.xy) + 37'(qp.wz));
    e[4] = 37'(qp.ww) - 37'(qp.xx) + 37'(qp.yy) - 37'(qp.zz);
    e[5] = 37'(2) * (37'(qp.yz) - 37'(qp.wx));
    e[6] = 37'(2) * (37'(qp.xz) - 37'(qp.wy));
    e[7] = 37'(2) * (37'(qp.yz) + 37'(qp.wx));
    e[8] = 37'(qp.ww) - 37'(qp.xx) - 37'(qp.yy) + 37'(qp.zz);
    for (int k = 0; k < 9; k++) begin
      er[k]  = e[k] + 37'sd128;
      r_n[k] = RW'(er[k] >>> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= r_n;
      p2 <= p1;
      t2 <= t1;
    end
  end

  // stage 3: nine products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m3[k] <= 61'(r2[k] * p2[k % 3]);
      t3 <= t2;
    end
  end

  // stage 4: row sums, round Q.36 to Q.16, add translation
  always_comb begin
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = 64'(m3[3*i]) + 64'(m3[3*i+1]) + 64'(m3[3*i+2]) + 64'sd524288;
      c_n[i] = w2p_pkg::CamW'(acc >>> 20) + w2p_pkg::CamW'(t3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx <= c_n[0];
      cy <= c_n[1];
      cz <= c_n[2];
    end
  end
endmodule

@@ design/w2p_divide.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, truncating toward zero.
// BitsPerStage quotient bits per register stage.
module w2p_divide #(
  parameter int NumBits      = 73,
  parameter int DenBits      = 52,
  parameter int BitsPerStage = 4
) (
  input  logic               clk,
  input  logic               en,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  input  logic               neg,
  output logic [NumBits-1:0] quo,
  output logic               quo_neg
);
  localparam int Stages = (NumBits + BitsPerStage - 1) / BitsPerStage;
  localparam int PadW   = Stages * BitsPerStage;

  logic [PadW-1:0]    n_s  [Stages+1];
  logic [DenBits:0]   r_s  [Stages+1];
  logic [DenBits-1:0] d_s  [Stages+1];
  logic [Stages:0]    g_s;

  assign n_s[0] = PadW'(num);
  assign r_s[0] = '0;
  assign d_s[0] = den;
  assign g_s[0] = neg;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [PadW-1:0]  n_c;
    logic [DenBits:0] r_c;
    logic [DenBits+1:0] sh;
    always_comb begin
      n_c = n_s[s];
      r_c = r_s[s];
      sh  = '0;
      for (int b = 0; b < BitsPerStage; b++) begin
        sh  = {r_c, n_c[PadW-1]};
        n_c = {n_c[PadW-2:0], 1'b0};
        if (sh >= (DenBits+2)'(d_s[s])) begin
          sh     = sh - (DenBits+2)'(d_s[s]);
          n_c[0] = 1'b1;
        end
        r_c = sh[DenBits:0];
      end
    end
    logic [PadW-1:0]    n_q;
    logic [DenBits:0]   r_q;
    logic [DenBits-1:0] d_q;
    logic               g_q;
    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= n_c;
        r_q <= r_c;
        d_q <= d_s[s];
        g_q <= g_s[s];
      end
    end
    assign n_s[s+1] = n_q;
    assign r_s[s+1] = r_q;
    assign d_s[s+1] = d_q;
    assign g_s[s+1] = g_q;
  end

  assign quo     = n_s[Stages][NumBits-1:0];
  assign quo_neg = g_s[Stages];
endmodule

@@ design/w2p_project.sv @@
`timescale 1ns / 1ps
// Pinhole projection for both axes: multiply by focal length, divide by depth,
// add centre, clamp.
module w2p_project (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [w2p_pkg::CamW-1:0]   cx, cy, cz,
  input  logic [w2p_pkg::CfgW-1:0]          fx, fy, ccx, ccy,
  output w2p_pkg::pix_t                     pix
);
  localparam int CW = w2p_pkg::CamW;
  localparam int NW = w2p_pkg::NumW;

  // stage A: magnitudes of the coordinates
  logic [CW-1:0] ax, ay, az;
  logic          sx, sy, sz, zz_a;
  always_ff @(posedge clk) begin
    if (en) begin
      ax <= cx[CW-1] ? CW'(-cx) : CW'(cx);
      ay <= cy[CW-1] ? CW'(-cy) : CW'(cy);
      az <= cz[CW-1] ? CW'(-cz) : CW'(cz);
      sx <= cx[CW-1]; sy <= cy[CW-1]; sz <= cz[CW-1];
      zz_a <= (cz == '0);
    end
  end

  // stage B: focal products (52x20, kept at full width into the divider)
  logic [NW-1:0] nu, nv;
  logic [CW-1:0] az_b;
  logic          gu, gv, zz_b;
  always_ff @(posedge clk) begin
    if (en) begin
      nu   <= NW'(ax) * NW'(fx);
      nv   <= NW'(ay) * NW'(fy);
      az_b <= az;
      gu   <= sx ^ sz;
      gv   <= sy ^ sz;
      zz_b <= zz_a;
    end
  end

  logic [NW-1:0] qu, qv;
  logic          qgu, qgv;
  w2p_divide #(.NumBits(NW), .DenBits(CW), .BitsPerStage(w2p_pkg::DivStep)) u_div_u (
    .clk(clk), .en(en), .num(nu), .den(az_b), .neg(gu), .quo(qu), .quo_neg(qgu)
  );
  w2p_divide #(.NumBits(NW), .DenBits(CW), .BitsPerStage(w2p_pkg::DivStep)) u_div_v (
    .clk(clk), .en(en), .num(nv), .den(az_b), .neg(gv), .quo(qv), .quo_neg(qgv)
  );

  // depth-zero flag alongside the divider
  localparam int DivStages = w2p_pkg::DivStages;
  logic [DivStages-1:0] zz_d;
  always_ff @(posedge clk) begin
    if (en) zz_d <= {zz_d[DivStages-2:0], zz_b};
  end

  // stage C: sign, centre, clamp
  logic signed [NW+1:0] su, sv;
  logic su_hi, su_lo, sv_hi, sv_lo;
  always_comb begin
    su = (qgu ? -$signed({2'b00, qu}) : $signed({2'b00, qu})) + (NW+2)'(ccx);
    sv = (qgv ? -$signed({2'b00, qv}) : $signed({2'b00, qv})) + (NW+2)'(ccy);
    su_hi = su > (NW+2)'(64'sh7FFFFFFF);
    su_lo = su < -(NW+2)'(64'sh80000000);
    sv_hi = sv > (NW+2)'(64'sh7FFFFFFF);
    sv_lo = sv < -(NW+2)'(64'sh80000000);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zz_d[DivStages-1]) begin
        pix <= '{depth_zero: 1'b1, saturated: 1'b0, u: '0, v: '0};
      end else begin
        pix.depth_zero <= 1'b0;
        pix.saturated  <= su_hi | su_lo | sv_hi | sv_lo;
        pix.u <= su_hi ? 32'sh7FFFFFFF : su_lo ? 32'sh80000000 : su[31:0];
        pix.v <= sv_hi ? 32'sh7FFFFFFF : sv_lo ? 32'sh80000000 : sv[31:0];
      end
    end
  end
endmodule

@@ design/world_to_pixel_projection_core.sv @@
`timescale 1ns / 1ps
// Channel | dir | tdata fields (low bit up)                          | tuser
// s_axis  | in  | point_x,y,z(32) quat_w,x,y,z(16) trans_x,y,z(32)  | -
// m_axis  | out | pixel_u(32) pixel_v(32)                            | depth_zero, saturated
// cfg     | in  | cfg_we, cfg_index(2), cfg_data(20)                 | -
// One point per cycle while the pipeline is not stalled; 4 rotation stages, 2 projection
// stages, 19 divider stages (4 quotient bits each), 1 clamp stage, 1 output
// register. The skid register is filled only while the output is held.
// rst clears valid bits and the intrinsics. A stall freezes the whole pipeline;
// the skid register lets tready stay high while one result waits.
module world_to_pixel_projection_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,   // point_x,y,z quat_w,x,y,z trans_x,y,z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // pixel_u, pixel_v
  output logic [1:0]   m_axis_tuser,   // depth_zero, saturated
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);
  localparam int Latency = 4 + 2 + w2p_pkg::DivStages + 1;

  logic [19:0] fx, fy, ccx, ccy;
  always_ff @(posedge clk) begin
    if (rst) begin
      fx <= '0; fy <= '0; ccx <= '0; ccy <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        w2p_pkg::CFG_FOCAL_X:  fx  <= cfg_data;
        w2p_pkg::CFG_FOCAL_Y:  fy  <= cfg_data;
        w2p_pkg::CFG_CENTER_X: ccx <= cfg_data;
        w2p_pkg::CFG_CENTER_Y: ccy <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result sits at the end with the skid full
  logic en;
  logic [Latency-1:0] vld;
  logic skid_v, out_v;
  w2p_pkg::pix_t pix, skid, outr;

  assign en = !(vld[Latency-1] && skid_v);
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Latency-2:0], s_axis_tvalid};
  end

  logic signed [w2p_pkg::CamW-1:0] cx, cy, cz;
  w2p_rotate u_rot (
    .clk(clk), .en(en),
    .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
    .qw(s_axis_tdata[111:96]), .qx(s_axis_tdata[127:112]),
    .qy(s_axis_tdata[143:128]), .qz(s_axis_tdata[159:144]),
    .tx(s_axis_tdata[191:160]), .ty(s_axis_tdata[223:192]),
    .tz(s_axis_tdata[255:224]),
    .cx(cx), .cy(cy), .cz(cz)
  );

  w2p_project u_proj (
    .clk(clk), .en(en), .cx(cx), .cy(cy), .cz(cz),
    .fx(fx), .fy(fy), .ccx(ccx), .ccy(ccy), .pix(pix)
  );

  // output register plus skid: tail item goes to out, or skid if out is held
  logic take_out;
  assign take_out = !out_v || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (take_out) begin
        if (skid_v) begin
          outr <= skid; out_v <= 1'b1; skid_v <= 1'b0;
        end else if (vld[Latency-1] && en) begin
          outr <= pix; out_v <= 1'b1;
        end else begin
          out_v <= 1'b0;
        end
      end else if (vld[Latency-1] && en) begin
        skid <= pix; skid_v <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {outr.v, outr.u};
  assign m_axis_tuser  = {outr.saturated, outr.depth_zero};
endmodule

@@ design/w2p_checker.sv @@
`timescale 1ns / 1ps
module w2p_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        s_axis_tready
);
  a_zero_px: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("depth-zero result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");
endmodule

bind world_to_pixel_projection_core w2p_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .s_axis_tready(s_axis_tready)
);
